FILE: hdl/lmra_pkg.sv
package lmra_pkg;
   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;
   localparam logic [1:0] SEL_BLACK = 2'd3;
   localparam logic [2:0] REG_DECAY  = 3'd0;
   localparam logic [2:0] REG_FALL   = 3'd1;
   localparam logic [2:0] REG_SPAWN  = 3'd2;
   localparam logic [2:0] REG_THRESH = 3'd3;
   localparam logic [2:0] REG_TINT   = 3'd4;
   localparam logic [2:0] REG_SELECT = 3'd5;
   localparam logic [2:0] REG_SEED   = 3'd6;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam logic [14:0] RAND_MAX_VAL = 15'h7FFF;
   localparam logic [7:0] FULL = 8'hFF;
endpackage

FILE: hdl/led_matrix_rain_animator.sv
// Channel | Dir | Payload
// req     | in  | tdata[15:0] elapsed_ms
// rsp     | out | tdata[31:0] row,col,red,green,blue (pad), tlast frame_last
// csr     | in  | APB, 7 registers at 4*i
// A tick holds req_tready low until the last pixel is registered for output and,
// when a fall runs, until the fall pass ends; every division goes through one serial divider.
// Each pixel steps through update, shade setup, a divider wait and output.
// Synchronous reset clears the map through ROWS*COLS valid bits; the result
// register stalls the sequencer while it holds a result and rsp_tready is low.
module led_matrix_rain_animator import lmra_pkg::*; #(
   parameter int ROWS = 4,
   parameter int COLS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // elapsed_ms
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_row[2:0] pixel_col[6:3] red green blue, pad
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int NPIX = ROWS * COLS;
   localparam int RW = $clog2(ROWS);
   localparam int PW = $clog2(NPIX);
   localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;

   localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_LIM = 4'd2, S_PIX = 4'd3,
      S_SHD = 4'd4, S_SHW = 4'd5, S_OUT = 4'd6, S_FALL = 4'd7, S_DECW = 4'd8,
      S_LIMW = 4'd9, S_FMV = 4'd10;

   logic [15:0] decay_ms_ff, period_ff, seed_ff, lfsr_ff, lfsr_in, timer_ff, timer_in;
   logic [14:0] sdiv_ff;
   logic [7:0]  thr_ff, tint_ff;
   logic [1:0]  csel_ff;
   logic        fell_ff, fell_in;
   logic [3:0]  st_ff, st_in;
   logic [7:0]  map_ff [NPIX];
   logic [NPIX-1:0] vld_ff;
   logic [7:0]  rd_ff;
   logic        rdv_ff;
   logic [PW-1:0] pix_ff, pix_in;
   logic [RW-1:0] row_ff, row_in, row_nx;
   logic [CW-1:0] col_ff, col_in, col_nx;
   logic        last_pix;
   logic        pfull_ff, pfull_in;
   logic [15:0] elap_ff, elap_in;
   logic [7:0]  decay_ff, decay_in, lvl_ff, lvl_in, pri_ff, pri_in, sec_ff, sec_in;
   logic [14:0] lim_ff, lim_in;
   logic        ov_ff, ov_in, ol_ff, ol_in;
   logic [31:0] od_ff, od_in;
   logic        wr_en;
   logic [7:0]  wr_val, cur;
   logic        dstart, ddone;
   logic [23:0] dnd, dq;
   logic [15:0] dsr;
   logic [16:0] tsum;
   logic [15:0] lnext;
   logic        cw;
   logic [7:0]  r8, g8, b8;

   lmra_divider u_div (.clock, .reset, .start(dstart), .dividend(dnd), .divisor(dsr),
      .done(ddone), .quotient(dq));

   assign cw = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_DECAY:  csr_prdata = {16'd0, decay_ms_ff};
         REG_FALL:   csr_prdata = {16'd0, period_ff};
         REG_SPAWN:  csr_prdata = {17'd0, sdiv_ff};
         REG_THRESH: csr_prdata = {24'd0, thr_ff};
         REG_TINT:   csr_prdata = {24'd0, tint_ff};
         REG_SELECT: csr_prdata = {30'd0, csel_ff};
         REG_SEED:   csr_prdata = {16'd0, seed_ff};
         default: csr_prdata = '0;
      endcase
   end

   assign last_pix = pix_ff == PW'(NPIX - 1);
   assign row_nx = (row_ff == RW'(ROWS - 1)) ? '0 : row_ff + 1'b1;
   assign col_nx = (row_ff == RW'(ROWS - 1)) ? col_ff + 1'b1 : col_ff;
   assign cur = rdv_ff ? rd_ff : 8'd0;
   assign lnext = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
   assign req_tready = st_ff == S_IDLE;
   assign tsum = {1'b0, timer_ff} + {1'b0, req_tdata};

   always_comb begin
      st_in = st_ff; pix_in = pix_ff; elap_in = elap_ff; decay_in = decay_ff;
      lim_in = lim_ff; lvl_in = lvl_ff; pri_in = pri_ff; sec_in = sec_ff;
      timer_in = timer_ff; fell_in = fell_ff; lfsr_in = lfsr_ff;
      ov_in = ov_ff; ol_in = ol_ff; od_in = od_ff;
      row_in = row_ff; col_in = col_ff; pfull_in = pfull_ff;
      r8 = '0; g8 = '0; b8 = '0;
      wr_en = 1'b0; wr_val = cur; dstart = 1'b0; dnd = '0; dsr = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (st_ff)
         S_IDLE: if (req_tvalid) begin
            elap_in = req_tdata;
            timer_in = tsum[16] ? 16'hFFFF : tsum[15:0];
            pix_in = '0; row_in = '0; col_in = '0;
            st_in = S_DEC;
         end
         S_DEC: begin
            dstart = 1'b1; dnd = 24'(elap_ff) * 24'd255; dsr = decay_ms_ff; st_in = S_DECW;
         end
         S_DECW: if (ddone) begin
            decay_in = (dq > 24'd255) ? 8'hFF : dq[7:0]; st_in = S_LIM;
         end
         S_LIM: begin
            dstart = 1'b1; dnd = 24'(RAND_MAX_VAL); dsr = {1'b0, sdiv_ff}; st_in = S_LIMW;
         end
         S_LIMW: if (ddone) begin
            lim_in = dq[14:0]; st_in = S_PIX;
         end
         S_PIX: begin
            wr_en = 1'b1;
            if (row_ff == '0 && fell_ff && (lnext[14:0] < lim_ff)) wr_val = FULL;
            else if (cur != 8'd0 && cur != FULL)
               wr_val = (cur <= decay_ff) ? 8'd0 : cur - decay_ff;
            if (row_ff == '0 && fell_ff) lfsr_in = lnext;
            lvl_in = wr_val;
            st_in = S_SHD;
         end
         S_SHD: begin
            dstart = 1'b1;
            if (lvl_ff > thr_ff) begin
               pri_in = FULL;
               dnd = 24'(16'(tint_ff) * 16'(lvl_ff - thr_ff)); dsr = 16'(FULL - thr_ff);
            end else begin
               sec_in = '0;
               dnd = 24'(16'(lvl_ff) * 16'd255); dsr = 16'(thr_ff);
            end
            st_in = S_SHW;
         end
         S_SHW: if (ddone) begin
            if (lvl_ff > thr_ff) sec_in = dq[7:0];
            else pri_in = dq[7:0];
            st_in = S_OUT;
         end
         S_OUT: if (!ov_ff || rsp_tready) begin
            unique case (csel_ff)
               SEL_RED:   begin r8 = pri_ff; g8 = sec_ff; b8 = sec_ff; end
               SEL_GREEN: begin r8 = sec_ff; g8 = pri_ff; b8 = sec_ff; end
               SEL_BLUE:  begin r8 = sec_ff; g8 = sec_ff; b8 = pri_ff; end
               default:   begin r8 = '0; g8 = '0; b8 = '0; end
            endcase
            ov_in = 1'b1;
            od_in = {1'b0, b8, g8, r8, 4'(col_ff), 3'(row_ff)};
            ol_in = last_pix;
            if (last_pix) st_in = S_FALL;
            else begin
               pix_in = pix_ff + 1'b1; row_in = row_nx; col_in = col_nx; st_in = S_PIX;
            end
         end
         S_FALL: begin
            pix_in = '0; row_in = '0; col_in = '0; pfull_in = 1'b0;
            if (timer_ff > period_ff) begin
               fell_in = 1'b1; timer_in = '0; st_in = S_FMV;
            end else begin
               fell_in = 1'b0; st_in = S_IDLE;
            end
         end
         S_FMV: begin
            // move a full drop down one row, leave a fading pixel behind
            wr_en = 1'b1;
            if (row_ff != '0 && pfull_ff) wr_val = FULL;
            else if (cur == FULL) wr_val = 8'hFE;
            pfull_in = cur == FULL;
            if (last_pix) st_in = S_IDLE;
            else begin
               pix_in = pix_ff + 1'b1; row_in = row_nx; col_in = col_nx;
            end
         end
         default: st_in = S_IDLE;
      endcase
      if (cw && csr_paddr[4:2] == REG_SEED)
         lfsr_in = (csr_pwdata[15:0] == '0) ? 16'd1 : csr_pwdata[15:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) map_ff[pix_ff] <= wr_val;
      rd_ff <= map_ff[pix_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ms_ff <= 16'd2000; period_ff <= 16'd180; sdiv_ff <= 15'd18;
         thr_ff <= 8'd208; tint_ff <= 8'd192; csel_ff <= SEL_GREEN; seed_ff <= 16'd44257;
         lfsr_ff <= 16'd44257; st_ff <= S_IDLE; timer_ff <= '0; fell_ff <= 1'b0;
         vld_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; timer_ff <= timer_in; fell_ff <= fell_in; ov_ff <= ov_in;
         lfsr_ff <= lfsr_in;
         if (wr_en) vld_ff[pix_ff] <= 1'b1;
         if (cw) begin
            unique case (csr_paddr[4:2])
               REG_DECAY:  decay_ms_ff <= csr_pwdata[15:0];
               REG_FALL:   period_ff <= csr_pwdata[15:0];
               REG_SPAWN:  sdiv_ff <= csr_pwdata[14:0];
               REG_THRESH: thr_ff <= csr_pwdata[7:0];
               REG_TINT:   tint_ff <= csr_pwdata[7:0];
               REG_SELECT: csel_ff <= csr_pwdata[1:0];
               REG_SEED:   seed_ff <= csr_pwdata[15:0];
               default: ;
            endcase
         end
      end
      rdv_ff <= vld_ff[pix_in];
      pix_ff <= pix_in; row_ff <= row_in; col_ff <= col_in; pfull_ff <= pfull_in;
      elap_ff <= elap_in; decay_ff <= decay_in; lim_ff <= lim_in;
      lvl_ff <= lvl_in; pri_ff <= pri_in; sec_ff <= sec_in; od_ff <= od_in; ol_ff <= ol_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tlast = ol_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !(st_ff == S_OUT)) else $error("ready while emitting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule

FILE: hdl/lmra_divider.sv
// Restoring divider: 24-bit dividend, 16-bit divisor, one quotient bit per cycle.
module lmra_divider import lmra_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [23:0] quotient
);
   logic [23:0] q_ff, q_in;
   logic [16:0] r_ff, r_in;
   logic [15:0] d_ff, d_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {r_ff[15:0], q_ff[23]};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor; cnt_in = 5'd24; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[22:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in;
      end
   end

   assign done = busy_ff && cnt_ff == 5'd1;
   assign quotient = (d_ff == '0) ? '0 : q_in;
endmodule
